// ===== hw/rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, codes and constants of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  // field widths
  localparam int CMD_W       = 2;
  localparam int KEY_W       = 32;
  localparam int ST_W        = 3;
  localparam int CFG_W       = 11;
  localparam int CNT_W       = 11;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  // defaults and reset values
  localparam int DEF_NUM_BUCKETS  = 1024;
  localparam int DEF_POOL_ENTRIES = 1024;
  localparam int BUCKET_RESET     = 1024;

  // multiplicative hash constant
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_UPDATED   = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd5;
  localparam logic [ST_W-1:0] ST_CLEARED   = 3'd6;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_HEAD_RD,
    OP_HEAD_LATCH,
    OP_ENT_RD,
    OP_ADVANCE,
    OP_WR_VAL,
    OP_FREE_RD,
    OP_ALLOC,
    OP_UNLINK,
    OP_PUSH,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [ST_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic             div_last;
    logic             cur_nil;
    logic             key_match;
    logic             free_nil;
    logic             fresh_hit;
    logic             prev_nil;
    logic             clr_last;
    logic             out_free;
    logic [CMD_W-1:0] cmd;
  } dp_stat_t;

endpackage

// ===== hw/rtl/chained_hash_map_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_core
// Key-value map with multiplicative hash, per-bucket chains in a fixed pool.
// ----------------------------------------------------------------------------
// steps: accept, multiply, 32 remainder steps (one bit per cycle), head read,
//   a key compare per chain link visited, an end-of-chain check on a miss,
//   update and result
// one item at a time: s_tready_o is high only while idle
// clear: all NUM_BUCKETS bucket heads, one per cycle through the head memory
// reset: a clearing pass over all NUM_BUCKETS bucket heads with s_tready_o low;
//   configuration writes are taken throughout
module chained_hash_map_core #(
  parameter int NUM_BUCKETS  = chm_pkg::DEF_NUM_BUCKETS,
  parameter int POOL_ENTRIES = chm_pkg::DEF_POOL_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // [1:0] command, [33:2] key, [65:34] value_in, rest zero
  input  logic [chm_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // [2:0] status, [34:3] value_out, [45:35] entry_count, rest zero
  output logic [chm_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // number of buckets in use
  input  logic [chm_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o
);
  import chm_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  chm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // datapath and memories
  chm_datapath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (s_tdata_i[1:0]),
    .in_key_i    (s_tdata_i[33:2]),
    .in_val_i    (s_tdata_i[65:34]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

endmodule

// ===== hw/rtl/chm_datapath.sv =====
// ----------------------------------------------------------------------------
// chm_datapath
// Hash unit, bit-serial remainder, bucket and entry memories, free list
// and result register of the chained hash map.
// ----------------------------------------------------------------------------
module chm_datapath #(
  parameter int NUM_BUCKETS  = chm_pkg::DEF_NUM_BUCKETS,
  parameter int POOL_ENTRIES = chm_pkg::DEF_POOL_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [chm_pkg::CMD_W-1:0]      in_cmd_i,
  input  logic [chm_pkg::KEY_W-1:0]      in_key_i,
  input  logic [chm_pkg::KEY_W-1:0]      in_val_i,
  input  logic                           cfg_valid_i,
  input  logic [chm_pkg::CFG_W-1:0]      cfg_data_i,
  input  chm_pkg::dp_cmd_t               cmd_i,
  output chm_pkg::dp_stat_t              stat_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [chm_pkg::OUT_TDATA_W-1:0] m_tdata_o
);
  import chm_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int EW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int BC_RST = (NUM_BUCKETS < BUCKET_RESET) ? NUM_BUCKETS : BUCKET_RESET;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  // memories
  logic [LW-1:0]    heads_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] keys_mem  [POOL_ENTRIES];
  logic [KEY_W-1:0] vals_mem  [POOL_ENTRIES];
  logic [LW-1:0]    links_mem [POOL_ENTRIES];

  // control state
  logic [CFG_W-1:0] div_q;
  logic [BW-1:0]    clr_idx_q;
  logic [LW-1:0]    fresh_q, free_head_q;
  logic [LW-1:0]    held_q;
  logic             m_tvalid_q;

  // payload state
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q, val_q, hash_q;
  logic [CFG_W-1:0] rem_q;
  logic [4:0]       bit_cnt_q;
  logic [LW-1:0]    cur_q, prev_q, head_q;
  logic [LW-1:0]    head_rd_q, link_rd_q;
  logic [KEY_W-1:0] key_rd_q, val_rd_q;
  logic [ST_W-1:0]  res_status_q;
  logic [KEY_W-1:0] res_value_q;
  logic [CNT_W-1:0] res_count_q;

  logic [CFG_W:0]   trial;
  logic [CFG_W-1:0] rem_d;
  logic [BW-1:0]    bucket;
  logic [EW-1:0]    cur_idx, prev_idx, free_idx;
  logic [31:0]      cfg_wide;
  logic [CFG_W-1:0] div_d;
  logic             out_free;

  assign bucket   = BW'(rem_q);
  assign cur_idx  = EW'(cur_q);
  assign prev_idx = EW'(prev_q);
  assign free_idx = EW'(free_head_q);
  assign out_free = !m_tvalid_q || m_tready_i;

  // one restoring remainder step per cycle
  always_comb begin
    trial = {rem_q, hash_q[KEY_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = CFG_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = CFG_W'(trial);
    end
  end

  // bucket count clamp
  always_comb begin
    cfg_wide = 32'(cfg_data_i);
    if (cfg_data_i == '0) begin
      div_d = CFG_W'(1);
    end else if (cfg_wide > 32'(NUM_BUCKETS)) begin
      div_d = CFG_W'(NUM_BUCKETS);
    end else begin
      div_d = cfg_data_i;
    end
  end

  // status to controller
  always_comb begin
    stat_o.div_last  = &bit_cnt_q;
    stat_o.cur_nil   = (cur_q == NIL);
    stat_o.key_match = (key_rd_q == key_q);
    stat_o.free_nil  = (free_head_q == NIL);
    stat_o.fresh_hit = (fresh_q == free_head_q);
    stat_o.prev_nil  = (prev_q == NIL);
    stat_o.clr_last  = (clr_idx_q == BW'(NUM_BUCKETS - 1));
    stat_o.out_free  = out_free;
    stat_o.cmd       = cmd_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= CFG_W'(BC_RST);
      clr_idx_q   <= '0;
      fresh_q     <= '0;
      free_head_q <= '0;
      held_q      <= '0;
      m_tvalid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        div_q <= div_d;
      end
      case (cmd_i.op)
        OP_CLEAR: begin
          clr_idx_q   <= stat_o.clr_last ? '0 : clr_idx_q + 1'b1;
          fresh_q     <= '0;
          free_head_q <= '0;
          held_q      <= '0;
        end
        OP_ALLOC: begin
          if (stat_o.fresh_hit) begin
            free_head_q <= free_head_q + 1'b1;
            fresh_q     <= fresh_q + 1'b1;
          end else begin
            free_head_q <= link_rd_q;
          end
          held_q <= held_q + 1'b1;
        end
        OP_PUSH: begin
          free_head_q <= cur_q;
          if (held_q != '0) begin
            held_q <= held_q - 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd_i.op == OP_RESULT) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= in_cmd_i;
        key_q <= in_key_i;
        val_q <= in_val_i;
      end
      OP_MUL: begin
        hash_q    <= key_q * HASH_MULT;
        rem_q     <= '0;
        bit_cnt_q <= '0;
      end
      OP_DIV: begin
        hash_q    <= {hash_q[KEY_W-2:0], 1'b0};
        rem_q     <= rem_d;
        bit_cnt_q <= bit_cnt_q + 1'b1;
      end
      OP_HEAD_LATCH: begin
        cur_q  <= head_rd_q;
        head_q <= head_rd_q;
        prev_q <= NIL;
      end
      OP_ADVANCE: begin
        prev_q <= cur_q;
        cur_q  <= link_rd_q;
      end
      OP_RESULT: begin
        res_status_q <= cmd_i.status;
        res_value_q  <= (cmd_i.status == ST_FOUND) ? val_rd_q : '0;
        res_count_q  <= CNT_W'(held_q);
      end
      default: ;
    endcase
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) begin
      heads_mem[clr_idx_q] <= NIL;
    end else if (cmd_i.op == OP_ALLOC) begin
      heads_mem[bucket] <= free_head_q;
    end else if (cmd_i.op == OP_UNLINK && stat_o.prev_nil) begin
      heads_mem[bucket] <= link_rd_q;
    end
    if (cmd_i.op == OP_HEAD_RD) begin
      head_rd_q <= heads_mem[bucket];
    end
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ALLOC) begin
      keys_mem[free_idx] <= key_q;
    end
    if (cmd_i.op == OP_ENT_RD) begin
      key_rd_q <= keys_mem[cur_idx];
    end
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ALLOC) begin
      vals_mem[free_idx] <= val_q;
    end else if (cmd_i.op == OP_WR_VAL) begin
      vals_mem[cur_idx] <= val_q;
    end
    if (cmd_i.op == OP_ENT_RD) begin
      val_rd_q <= vals_mem[cur_idx];
    end
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ALLOC) begin
      links_mem[free_idx] <= head_q;
    end else if (cmd_i.op == OP_UNLINK && !stat_o.prev_nil) begin
      links_mem[prev_idx] <= link_rd_q;
    end else if (cmd_i.op == OP_PUSH) begin
      links_mem[cur_idx] <= free_head_q;
    end
    if (cmd_i.op == OP_ENT_RD) begin
      link_rd_q <= links_mem[cur_idx];
    end else if (cmd_i.op == OP_FREE_RD) begin
      link_rd_q <= links_mem[free_idx];
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {2'b00, res_count_q, res_value_q, res_status_q};

  // checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= LW'(POOL_ENTRIES)) else $error("held count above pool size");
  a_full_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == NIL) |-> (held_q == LW'(POOL_ENTRIES)))
    else $error("free list empty while pool not fully held");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q != '0) else $error("bucket divisor is zero");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RESULT) |=> m_tvalid_q) else $error("result not presented");

endmodule

// ===== hw/rtl/chm_ctrl.sv =====
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer of the chained hash map: clearing pass, hash, remainder, chain walk,
// update and result hand-off.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  chm_pkg::dp_stat_t stat_i,
  output chm_pkg::dp_cmd_t  cmd_o
);
  import chm_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_HEADL = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_ACT   = 4'd9;
  localparam logic [3:0] S_FREE  = 4'd10;
  localparam logic [3:0] S_ALLOC = 4'd11;
  localparam logic [3:0] S_REM   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [ST_W-1:0] res_q, res_d;
  dp_op_e          op;

  // next state and datapath operation
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    op      = OP_NONE;
    unique case (state_q)
      S_INIT: begin
        op = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          op      = OP_LOAD;
          state_d = S_MUL;
        end
      end
      S_CLR: begin
        op = OP_CLEAR;
        if (stat_i.clr_last) begin
          res_d   = ST_CLEARED;
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        op      = OP_MUL;
        state_d = (stat_i.cmd == CMD_CLEAR) ? S_CLR : S_DIV;
      end
      S_DIV: begin
        op = OP_DIV;
        if (stat_i.div_last) state_d = S_HEAD;
      end
      S_HEAD: begin
        op      = OP_HEAD_RD;
        state_d = S_HEADL;
      end
      S_HEADL: begin
        op      = OP_HEAD_LATCH;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (stat_i.cur_nil) begin
          state_d = S_ACT;
        end else begin
          op      = OP_ENT_RD;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.key_match) begin
          state_d = S_ACT;
        end else begin
          op      = OP_ADVANCE;
          state_d = S_CHK;
        end
      end
      S_ACT: begin
        state_d = S_OUT;
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (!stat_i.cur_nil) begin
              op    = OP_WR_VAL;
              res_d = ST_UPDATED;
            end else if (stat_i.free_nil) begin
              res_d = ST_FULL;
            end else if (stat_i.fresh_hit) begin
              state_d = S_ALLOC;
            end else begin
              op      = OP_FREE_RD;
              state_d = S_ALLOC;
            end
          end
          CMD_LOOKUP: begin
            res_d = stat_i.cur_nil ? ST_NOT_FOUND : ST_FOUND;
          end
          default: begin
            if (stat_i.cur_nil) begin
              res_d = ST_NOT_FOUND;
            end else begin
              op      = OP_UNLINK;
              state_d = S_REM;
            end
          end
        endcase
      end
      S_FREE: begin
        state_d = S_ALLOC;
      end
      S_ALLOC: begin
        op      = OP_ALLOC;
        res_d   = ST_INSERTED;
        state_d = S_OUT;
      end
      S_REM: begin
        op      = OP_PUSH;
        res_d   = ST_REMOVED;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          op      = OP_RESULT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      res_q   <= ST_NOT_FOUND;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign s_tready_o    = (state_q == S_IDLE);
  assign cmd_o.op      = op;
  assign cmd_o.status  = res_q;

  // checks
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_LOAD) |-> (state_q == S_IDLE)) else $error("item loaded outside idle");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_RESULT) |=> (state_q == S_IDLE)) else $error("result not followed by idle");
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && stat_i.div_last) |=> (state_q == S_HEAD))
    else $error("remainder done but no head read");

endmodule
